[rtl/rist_pkg.sv]
// ----------------------------------------------------------------------------
// rist_pkg: shared types and constants of the radial influence stamp
// Fixed-point format, word types and pipeline sizing.
// ----------------------------------------------------------------------------
package rist_pkg;

  localparam int FRAC_BITS = 14;
  localparam int INF_W     = 16;
  localparam logic signed [INF_W-1:0] ONE_Q = INF_W'(1 << FRAC_BITS);

  // distance pipeline
  localparam int SUM_W      = 17;
  localparam int RAD_W      = 18;
  localparam int ROOT_W     = 9;
  localparam int SREM_W     = 12;
  localparam int SQRT_STEPS = 3;
  localparam int SQRT_STG   = ROOT_W / SQRT_STEPS;

  // divider pipeline: quotient of num * 2^FRAC_BITS / den, num <= den
  localparam int DIV_W     = 16;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DREM_W    = DIV_W + 1;
  localparam int DIV_STEPS = 3;
  localparam int DIV_STG   = QUO_W / DIV_STEPS;

  typedef enum logic [1:0] {
    CFG_CURVE_MODE   = 2'd0,
    CFG_OUTER_RADIUS = 2'd1,
    CFG_INNER_RADIUS = 2'd2,
    CFG_MAP_SIZE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CURVE_CONST  = 2'd0,
    CURVE_LINEAR = 2'd1,
    CURVE_QUAD   = 2'd2,
    CURVE_DISC   = 2'd3
  } curve_e;

  typedef struct packed {
    logic [7:0] cell_x;
    logic [7:0] cell_y;
  } cell_t;

  typedef struct packed {
    logic signed [INF_W-1:0] influence;
    logic [7:0]              distance;
  } result_t;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    use_div;
    logic                    neg;
    logic signed [INF_W-1:0] fixed_val;
    logic [7:0]              dist_sat;
  } side_t;

endpackage

[rtl/rist_dist.sv]
// ----------------------------------------------------------------------------
// rist_dist: truncated distance from the grid center
// Offsets, sum of squares, then a three stage integer square root.
// ----------------------------------------------------------------------------
module rist_dist import rist_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cell_t             cell_i,
  input  logic [8:0]        map_size_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [7:0]       centre;
  logic [7:0]       dx_d, dy_d, dx_q, dy_q;
  logic             v1_q, v2_q;
  logic [15:0]      sqx, sqy;
  logic [SUM_W-1:0] sum_q;

  assign centre = map_size_i[8:1];
  assign dx_d = (cell_i.cell_x > centre) ? cell_i.cell_x - centre : centre - cell_i.cell_x;
  assign dy_d = (cell_i.cell_y > centre) ? cell_i.cell_y - centre : centre - cell_i.cell_y;
  assign sqx  = 16'(dx_q) * 16'(dx_q);
  assign sqy  = 16'(dy_q) * 16'(dy_q);

  logic              sv_p   [SQRT_STG+1];
  logic [SREM_W-1:0] rem_p  [SQRT_STG+1];
  logic [ROOT_W-1:0] root_p [SQRT_STG+1];
  logic [RAD_W-1:0]  rad_p  [SQRT_STG+1];

  assign sv_p[0]   = v2_q;
  assign rem_p[0]  = '0;
  assign root_p[0] = '0;
  assign rad_p[0]  = {1'b0, sum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sum_q <= {1'b0, sqx} + {1'b0, sqy};
  end

  for (genvar g = 0; g < SQRT_STG; g++) begin : g_sqrt
    logic [SREM_W-1:0] rem_d;
    logic [ROOT_W-1:0] root_d;
    logic [RAD_W-1:0]  rad_d;

    // one root bit per step: bring down two radicand bits, try 4*root+1
    always_comb begin
      logic [SREM_W-1:0] r2;
      logic [SREM_W-1:0] trial;
      rem_d  = rem_p[g];
      root_d = root_p[g];
      rad_d  = rad_p[g];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        r2    = {rem_d[SREM_W-3:0], rad_d[RAD_W-1 -: 2]};
        rad_d = {rad_d[RAD_W-3:0], 2'b00};
        trial = {1'b0, root_d, 2'b01};
        if (r2 >= trial) begin
          rem_d  = r2 - trial;
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = r2;
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_p[g+1] <= 1'b0;
      end else begin
        sv_p[g+1] <= sv_p[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_p[g+1]  <= rem_d;
      root_p[g+1] <= root_d;
      rad_p[g+1]  <= rad_d;
    end
  end

  assign valid_o = sv_p[SQRT_STG];
  assign root_o  = root_p[SQRT_STG];

endmodule

[rtl/rist_div.sv]
// ----------------------------------------------------------------------------
// rist_div: pipelined restoring divider
// Gives num * 2^FRAC_BITS / den for num <= den, three quotient bits a stage.
// ----------------------------------------------------------------------------
module rist_div import rist_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  div_req_t         req_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output side_t            side_o
);

  logic              v_p    [DIV_STG+1];
  logic [DREM_W-1:0] rem_p  [DIV_STG+1];
  logic [DIV_W-1:0]  den_p  [DIV_STG+1];
  logic [QUO_W-1:0]  quo_p  [DIV_STG+1];
  side_t             side_p [DIV_STG+1];

  assign v_p[0]    = valid_i;
  assign rem_p[0]  = {1'b0, req_i.num};
  assign den_p[0]  = req_i.den;
  assign quo_p[0]  = '0;
  assign side_p[0] = side_i;

  for (genvar g = 0; g < DIV_STG; g++) begin : g_div
    logic [DREM_W-1:0] rem_d;
    logic [QUO_W-1:0]  quo_d;

    // compare and subtract, then shift the remainder for the next bit
    always_comb begin
      rem_d = rem_p[g];
      quo_d = quo_p[g];
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (rem_d >= {1'b0, den_p[g]}) begin
          rem_d = rem_d - {1'b0, den_p[g]};
          quo_d = {quo_d[QUO_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QUO_W-2:0], 1'b0};
        end
        rem_d = {rem_d[DREM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_p[g+1] <= 1'b0;
      end else begin
        v_p[g+1] <= v_p[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_p[g+1]  <= rem_d;
      den_p[g+1]  <= den_p[g];
      quo_p[g+1]  <= quo_d;
      side_p[g+1] <= side_p[g];
    end
  end

  assign valid_o = v_p[DIV_STG];
  assign quo_o   = quo_p[DIV_STG];
  assign side_o  = side_p[DIV_STG];

endmodule

[rtl/radial_influence_stamp_unit.sv]
// ----------------------------------------------------------------------------
// radial_influence_stamp_unit: radial falloff value of one template cell
// Throughput: one cell a cycle; busy never rises, the pipeline has no stall.
// Depth: offset and sum registers, the 3 stage square root, the curve select register, the 5 stage divider, output.
// Reset clears the configuration registers to their defaults and empties the pipeline.
// The receiver cannot stall: each result word shows for one cycle only.
// ----------------------------------------------------------------------------
module radial_influence_stamp_unit import rist_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  cell_t      cell_i,
  output logic       result_valid_o,
  output result_t    result_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i
);

  // Configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it.
  curve_e      curve_q;
  logic [7:0]  outer_q, inner_q;
  logic [8:0]  map_size_q;
  logic [15:0] r_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q    <= CURVE_CONST;
      outer_q    <= '0;
      inner_q    <= '0;
      map_size_q <= 9'd1;
      r_sq_q     <= '0;
    end else begin
      // hold R*R ready for the quadratic curve
      r_sq_q <= 16'(outer_q) * 16'(outer_q);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CURVE_MODE:   curve_q    <= curve_e'(cfg_data_i[1:0]);
          CFG_OUTER_RADIUS: outer_q    <= cfg_data_i[7:0];
          CFG_INNER_RADIUS: inner_q    <= cfg_data_i[7:0];
          CFG_MAP_SIZE:     map_size_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Accept a word every cycle.
  assign busy = 1'b0;

  // Distance stages.
  logic              dist_valid;
  logic [ROOT_W-1:0] d;

  rist_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start),
    .cell_i     (cell_i),
    .map_size_i (map_size_q),
    .valid_o    (dist_valid),
    .root_o     (d)
  );

  // Curve select: turn d into a divider request or a fixed value.
  logic [17:0] dsq;
  logic [8:0]  r9, ri9;
  div_req_t    req_d, req_q;
  side_t       side_d, side_q;
  logic        prep_valid_q;

  assign dsq = 18'(d) * 18'(d);
  assign r9  = {1'b0, outer_q};
  assign ri9 = {1'b0, inner_q};

  always_comb begin
    req_d            = '0;
    side_d           = '0;
    side_d.dist_sat  = (d > 9'd255) ? 8'd255 : d[7:0];
    case (curve_q)
      CURVE_CONST: begin
        side_d.fixed_val = ONE_Q;
      end
      CURVE_LINEAR: begin
        if (outer_q != 8'd0 && d < r9) begin
          side_d.use_div = 1'b1;
          req_d.num      = DIV_W'(r9 - d);
          req_d.den      = DIV_W'(outer_q);
        end
      end
      CURVE_QUAD: begin
        if (outer_q != 8'd0 && d < r9) begin
          side_d.use_div = 1'b1;
          req_d.num      = r_sq_q - dsq[15:0];
          req_d.den      = r_sq_q;
        end
      end
      CURVE_DISC: begin
        if (d <= ri9) begin
          // negative core; a zero inner radius gives 0
          if (inner_q != 8'd0) begin
            side_d.use_div = 1'b1;
            side_d.neg     = 1'b1;
            req_d.num      = DIV_W'(ri9 - d);
            req_d.den      = DIV_W'(inner_q);
          end
        end else if (d < r9) begin
          side_d.fixed_val = ONE_Q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else begin
      prep_valid_q <= dist_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    side_q <= side_d;
  end

  // Divider stages.
  logic             div_valid;
  logic [QUO_W-1:0] quo;
  side_t            div_side;

  rist_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid_q),
    .req_i   (req_q),
    .side_i  (side_q),
    .valid_o (div_valid),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  // Output register: apply sign or fixed value, drive the strobe.
  logic signed [INF_W-1:0] q_ext;
  result_t                 res_d;
  logic                    res_valid_q;
  result_t                 res_q;

  assign q_ext = INF_W'(quo);

  always_comb begin
    res_d.distance = div_side.dist_sat;
    if (div_side.use_div) begin
      res_d.influence = div_side.neg ? -q_ext : q_ext;
    end else begin
      res_d.influence = div_side.fixed_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for radial_influence_stamp_unit
// Drives cell words under random idle gaps and keeps its own prediction of
// the falloff curve, checking every result word against the oldest one.
// ----------------------------------------------------------------------------
module tb;
  import rist_pkg::*;

  localparam int  LATENCY = 12;
  localparam int  ONE_INT = 1 << FRAC_BITS;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  cell_t      cell_i = '0;
  logic       result_valid_o;
  result_t    result_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [8:0] cfg_data_i = '0;

  radial_influence_stamp_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // Mirror of the configuration registers, updated at each write edge.
  curve_e     mode_q   = CURVE_CONST;
  logic [7:0] outer_q  = '0;
  logic [7:0] inner_q  = '0;
  logic [8:0] size_q   = 9'd1;

  result_t    falloff_q[$];
  int         errors      = 0;
  int         words_sent  = 0;
  int         words_seen  = 0;
  bit         no_idle     = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // Integer square root by linear search; sums stay below 2^17.
  function automatic int root_of(input int s);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  function automatic result_t predict_falloff(input cell_t c);
    result_t res;
    int      ctr, dx, dy, d;
    longint  r, ri, v;
    ctr = int'(size_q >> 1);
    dx  = int'(c.cell_x) - ctr;
    dy  = int'(c.cell_y) - ctr;
    d   = root_of(dx * dx + dy * dy);
    r   = longint'(outer_q);
    ri  = longint'(inner_q);
    case (mode_q)
      CURVE_CONST:  v = ONE_INT;
      CURVE_LINEAR: v = (r == 0 || d >= r) ? 0 : (ONE_INT * (r - d)) / r;
      CURVE_QUAD:   v = (r == 0 || d >= r) ? 0 : (ONE_INT * (r * r - d * d)) / (r * r);
      default: begin
        if (d <= ri) v = (ri == 0) ? 0 : -((ONE_INT * (ri - d)) / ri);
        else         v = (d < r) ? ONE_INT : 0;
      end
    endcase
    res.influence = v[INF_W-1:0];
    res.distance  = (d > 255) ? 8'd255 : d[7:0];
    return res;
  endfunction

  // One process at the edge: check the result, then record config and cells.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        words_seen++;
        if (falloff_q.size() == 0) begin
          report("result word with nothing pending");
        end else begin
          want = falloff_q.pop_front();
          if (result_o.influence !== want.influence)
            report($sformatf("influence %0d, want %0d", result_o.influence, want.influence));
          if (result_o.distance !== want.distance)
            report($sformatf("distance %0d, want %0d", result_o.distance, want.distance));
        end
      end
      if (start && !busy) falloff_q.push_back(predict_falloff(cell_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CURVE_MODE:   mode_q  = curve_e'(cfg_data_i[1:0]);
          CFG_OUTER_RADIUS: outer_q = cfg_data_i[7:0];
          CFG_INNER_RADIUS: inner_q = cfg_data_i[7:0];
          CFG_MAP_SIZE:     size_q  = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Hold start until the word is taken, then optionally idle.
  task automatic send_cell(input logic [7:0] x, input logic [7:0] y);
    int gap;
    start  <= 1'b1;
    cell_i <= '{cell_x: x, cell_y: y};
    do @(posedge clk_i); while (busy);
    words_sent++;
    if (no_idle) gap = 0;
    else if ($urandom_range(0, 9) < 4) gap = 0;
    else if ($urandom_range(0, 9) < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and let the pipeline empty before touching registers.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (falloff_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [8:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_curve(input curve_e m, input logic [7:0] r, input logic [7:0] ri,
                           input logic [8:0] sz);
    drain();
    write_reg(CFG_CURVE_MODE, 9'(m));
    write_reg(CFG_OUTER_RADIUS, 9'(r));
    write_reg(CFG_INNER_RADIUS, 9'(ri));
    write_reg(CFG_MAP_SIZE, sz);
  endtask

  // Extremes, every curve, zero radius, disc centre, odd and zero map sizes.
  task automatic test_directed();
    send_cell(8'd0, 8'd0);                    // reset values: constant curve
    send_cell(8'd255, 8'd255);
    set_curve(CURVE_LINEAR, 8'd0, 8'd0, 9'd256);
    send_cell(8'd128, 8'd128);                // zero radius gives zero
    set_curve(CURVE_LINEAR, 8'd255, 8'd0, 9'd256);
    send_cell(8'd128, 8'd128);
    send_cell(8'd0, 8'd0);
    send_cell(8'd255, 8'd0);
    set_curve(CURVE_QUAD, 8'd255, 8'd0, 9'd256);
    send_cell(8'd128, 8'd128);
    send_cell(8'd200, 8'd60);
    set_curve(CURVE_DISC, 8'd20, 8'd0, 9'd64);
    send_cell(8'd32, 8'd32);                  // inner radius zero at centre
    send_cell(8'd40, 8'd32);
    set_curve(CURVE_DISC, 8'd20, 8'd10, 9'd64);
    send_cell(8'd32, 8'd32);
    send_cell(8'd42, 8'd32);                  // exactly on the inner edge
    send_cell(8'd47, 8'd32);
    send_cell(8'd60, 8'd60);
    set_curve(CURVE_DISC, 8'd255, 8'd255, 9'd511);   // centre at 255
    send_cell(8'd0, 8'd0);                    // distance saturates
    send_cell(8'd255, 8'd255);
    set_curve(CURVE_LINEAR, 8'd255, 8'd0, 9'd0);     // map size zero
    send_cell(8'd0, 8'd0);
    send_cell(8'd255, 8'd255);
  endtask

  // Random curve settings, each followed by a burst of random cells.
  task automatic test_random();
    int n;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 3))
        0:       set_curve(curve_e'($urandom_range(0, 3)), 8'd255, 8'($urandom), 9'd256);
        1:       set_curve(curve_e'($urandom_range(0, 3)), 8'($urandom),
                           8'($urandom_range(0, 15)), 9'($urandom_range(1, 64)));
        default: set_curve(curve_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                           9'($urandom));
      endcase
      no_idle = (ph % 4 == 3);
      n = $urandom_range(50, 70);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_cell(8'($urandom), 8'($urandom));
        else send_cell(8'($urandom_range(0, size_q > 0 ? size_q - 1 : 0)),
                       8'($urandom_range(0, size_q > 0 ? size_q - 1 : 0)));
      end
      no_idle = 0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain();
    if (falloff_q.size() != 0) report("results still pending at end");
    $display("sent %0d cell words, checked %0d result words over all four curves",
             words_sent, words_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
rtl/rist_pkg.sv
rtl/rist_dist.sv
rtl/rist_div.sv
rtl/radial_influence_stamp_unit.sv
tb/sv/tb.sv
